// ===== rtl/msl_pkg.sv =====
// ----------------------------------------------------------------------------
// msl_pkg
// Shared types and constants of the multi-channel slew limiter.
// ----------------------------------------------------------------------------
package msl_pkg;

    // command codes carried in tuser
    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_HALT  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // status codes
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_CHAN = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_MIN_POS  = 2'd0;
    localparam logic [1:0] REG_MAX_POS  = 2'd1;
    localparam logic [1:0] REG_STEP     = 2'd2;
    localparam logic [1:0] REG_PERIOD   = 2'd3;

    // configuration reset values
    localparam logic [7:0]  MIN_POS_RESET = 8'd0;
    localparam logic [7:0]  MAX_POS_RESET = 8'd180;
    localparam logic [7:0]  STEP_RESET    = 8'd2;
    localparam logic [15:0] PERIOD_RESET  = 16'd20;

    // positions come out of reset at the midpoint of the reset limits
    localparam int unsigned MID_POS_INT =
        (int'(MIN_POS_RESET) + int'(MAX_POS_RESET)) / 2;
    localparam logic [7:0] MID_POS = MID_POS_INT[7:0];

    localparam int unsigned MASK_W = 16;

    // controller to datapath
    typedef struct packed {
        logic accept;      // input transfer this cycle
        logic out_direct;  // result of a single-cycle command is loaded now
        logic walk_step;   // move the indexed channel toward its target
        logic walk_halt;   // freeze the indexed channel's target
    } msl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // result register empty or being drained
        logic tick_expire;  // the incoming tick ends a period
        logic idx_last;     // walk index on the last channel
    } msl_stat_t;

    typedef struct packed {
        logic              status;
        logic [7:0]        position;
        logic              at_target;
        logic [MASK_W-1:0] moved_mask;
    } msl_result_t;

endpackage

// ===== rtl/msl_ctrl.sv =====
// ----------------------------------------------------------------------------
// msl_ctrl
// Sequencer: single-cycle commands in idle, channel walk for step and halt.
// ----------------------------------------------------------------------------
module msl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [1:0]        cmd,
    input  msl_pkg::msl_stat_t stat,
    output logic              s_tready,
    output msl_pkg::msl_cmd_t  ctl
);
    import msl_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_STEP = 2'd1;
    localparam logic [1:0] ST_HALT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;
    logic       goes_walk;

    assign s_tready  = (state_reg == ST_IDLE) && stat.out_free;
    assign accept    = s_tvalid && s_tready;
    assign goes_walk = (cmd == CMD_HALT) || ((cmd == CMD_TICK) && stat.tick_expire);

    always_comb
    begin
        ctl.accept     = accept;
        ctl.out_direct = accept && !goes_walk;
        ctl.walk_step  = (state_reg == ST_STEP);
        ctl.walk_halt  = (state_reg == ST_HALT);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_HALT))
                begin
                    state_next = ST_HALT;
                end
                else if (accept && goes_walk)
                begin
                    state_next = ST_STEP;
                end
            end
            ST_STEP, ST_HALT:
            begin
                if (stat.idx_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/msl_datapath.sv =====
// ----------------------------------------------------------------------------
// msl_datapath
// Configuration, per-channel positions, tick counter and result register.
// ----------------------------------------------------------------------------
module msl_datapath #(
    parameter int NUM_CHANNELS = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [15:0]           cfg_wdata,
    input  logic [1:0]            cmd,
    input  logic [3:0]            channel,
    input  logic signed [10:0]    requested_position,
    input  logic                  m_tready,
    input  msl_pkg::msl_cmd_t     ctl,
    output msl_pkg::msl_stat_t    stat,
    output logic                  m_tvalid,
    output msl_pkg::msl_result_t  result
);
    import msl_pkg::*;

    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [7:0]  min_pos_reg;
    logic [7:0]  max_pos_reg;
    logic [7:0]  step_reg;
    logic [15:0] period_reg;
    logic [15:0] elapsed_reg;
    logic [15:0] elapsed_inc;

    logic [7:0] cur_reg [NUM_CHANNELS];
    logic [7:0] tgt_reg [NUM_CHANNELS];

    logic [CW-1:0]     idx_reg;
    logic [MASK_W-1:0] mask_reg;
    logic [MASK_W-1:0] mask_next;
    logic              out_valid_reg;
    msl_result_t       result_reg;
    msl_result_t       result_next;

    logic          walking;
    logic          ch_valid;
    logic [CW-1:0] addr;
    logic [7:0]    cur_rd;
    logic [7:0]    tgt_rd;
    logic [7:0]    diff;
    logic [7:0]    pos_next;
    logic          moved;
    logic [7:0]    clamped;

    assign walking  = ctl.walk_step || ctl.walk_halt;
    assign ch_valid = ({1'b0, channel} < 5'(NUM_CHANNELS));
    assign addr     = walking ? idx_reg : channel[CW-1:0];
    assign cur_rd   = cur_reg[addr];
    assign tgt_rd   = tgt_reg[addr];

    // one channel step toward its target, landing exactly on it
    always_comb
    begin
        pos_next = cur_rd;
        diff     = 8'd0;
        priority if (cur_rd < tgt_rd)
        begin
            diff     = tgt_rd - cur_rd;
            pos_next = (diff <= step_reg) ? tgt_rd : (cur_rd + step_reg);
        end
        else if (cur_rd > tgt_rd)
        begin
            diff     = cur_rd - tgt_rd;
            pos_next = (diff <= step_reg) ? tgt_rd : (cur_rd - step_reg);
        end
    end

    assign moved     = (pos_next != cur_rd);
    assign mask_next = mask_reg | (MASK_W'(moved) << idx_reg);

    // lower limit is tested first, so it wins for requests below it when the limits are inverted
    always_comb
    begin
        priority if (requested_position < $signed({3'b000, min_pos_reg}))
        begin
            clamped = min_pos_reg;
        end
        else if (requested_position > $signed({3'b000, max_pos_reg}))
        begin
            clamped = max_pos_reg;
        end
        else
        begin
            clamped = requested_position[7:0];
        end
    end

    assign elapsed_inc = (elapsed_reg == 16'hFFFF) ? elapsed_reg : (elapsed_reg + 16'd1);

    always_comb
    begin
        stat.out_free    = !out_valid_reg || m_tready;
        stat.tick_expire = (elapsed_inc >= period_reg);
        stat.idx_last    = (idx_reg == CW'(NUM_CHANNELS - 1));
    end

    always_comb
    begin
        result_next            = '0;
        result_next.status     = STATUS_OK;
        if (walking)
        begin
            result_next.moved_mask = ctl.walk_step ? mask_next : '0;
        end
        else if ((cmd == CMD_SET) || (cmd == CMD_QUERY))
        begin
            if (!ch_valid)
            begin
                result_next.status = STATUS_BAD_CHAN;
            end
            else if (cmd == CMD_QUERY)
            begin
                result_next.position  = cur_rd;
                result_next.at_target = (cur_rd == tgt_rd);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pos_reg <= MIN_POS_RESET;
            max_pos_reg <= MAX_POS_RESET;
            step_reg    <= STEP_RESET;
            period_reg  <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_MIN_POS: min_pos_reg <= cfg_wdata[7:0];
                REG_MAX_POS: max_pos_reg <= cfg_wdata[7:0];
                REG_STEP:    step_reg    <= cfg_wdata[7:0];
                REG_PERIOD:  period_reg  <= cfg_wdata;
                default:     period_reg  <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= 16'd0;
            idx_reg     <= '0;
            mask_reg    <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                cur_reg[i] <= MID_POS;
                tgt_reg[i] <= MID_POS;
            end
        end
        else
        begin
            if (ctl.accept)
            begin
                idx_reg  <= '0;
                mask_reg <= '0;
                if (cmd == CMD_TICK)
                begin
                    elapsed_reg <= stat.tick_expire ? 16'd0 : elapsed_inc;
                end
                if ((cmd == CMD_SET) && ch_valid)
                begin
                    tgt_reg[addr] <= clamped;
                end
            end
            else if (walking)
            begin
                idx_reg <= idx_reg + CW'(1);
                if (ctl.walk_step)
                begin
                    cur_reg[addr] <= pos_next;
                    mask_reg      <= mask_next;
                end
                else
                begin
                    tgt_reg[addr] <= cur_rd;
                end
            end
        end
    end

    // result register, loaded after a single-cycle command or at walk end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_direct || (walking && stat.idx_last))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_direct || (walking && stat.idx_last))
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign result   = result_reg;

endmodule

// ===== rtl/multi_channel_slew_limiter.sv =====
// ----------------------------------------------------------------------------
// set, query and a tick inside a period: result registered in the cycle after the transfer
// a tick that ends a period, or halt: a walk that visits one channel per cycle,
// a tick walk through the shared step unit; the result is loaded at walk end
// one item a cycle; a walk holds the input until it ends, and a
// full result register that is not being drained holds it too
// rst_n (async, active low) restores register defaults and puts every
// channel's current and target position at the midpoint, 90
// ----------------------------------------------------------------------------
// multi_channel_slew_limiter
// Slew-rate limited servo positions for several channels.
// ----------------------------------------------------------------------------
module multi_channel_slew_limiter #(
    parameter int NUM_CHANNELS = 5
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // channel[3:0], requested_position[14:4], zero[15]
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // position[7:0], at_target[8], moved_mask[24:9], zero[31:25]
    output logic        m_tuser    // status[0]
);
    import msl_pkg::*;

    msl_cmd_t    ctl;
    msl_stat_t   stat;
    msl_result_t result;

    msl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .cmd      (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .ctl      (ctl)
    );

    msl_datapath #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_datapath
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .cmd                (s_tuser),
        .channel            (s_tdata[3:0]),
        .requested_position (s_tdata[14:4]),
        .m_tready           (m_tready),
        .ctl                (ctl),
        .stat               (stat),
        .m_tvalid           (m_tvalid),
        .result             (result)
    );

    assign m_tdata = {7'd0, result.moved_mask, result.at_target, result.position};
    assign m_tuser = result.status;

endmodule

// ===== test/multi_channel_slew_limiter_test.sv =====
// ----------------------------------------------------------------------------
// multi_channel_slew_limiter_test
// Drives set, tick, halt and query commands into the slew limiter under a
// range of limit, step and period settings and compares every result against
// a cycle-free model of the channel positions.
// ----------------------------------------------------------------------------
module multi_channel_slew_limiter_test;

    import msl_pkg::*;

    localparam int NUM_CH        = 5;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int ITEMS_PER_SET = 250;

    // tracks current and target positions and predicts each result
    class slew_tracker_t;
        int          num_chan;
        logic [7:0]  lo_lim;
        logic [7:0]  hi_lim;
        logic [7:0]  step_size;
        logic [15:0] period;
        logic [7:0]  cur_pos [16];
        logic [7:0]  tgt_pos [16];
        int          elapsed;
        msl_result_t expected_results [$];
        int          errors;
        int          commands;
        int          compared;
        int          periods_fired;
        int          bad_chan;

        function new(int n);
            num_chan  = n;
            lo_lim    = MIN_POS_RESET;
            hi_lim    = MAX_POS_RESET;
            step_size = STEP_RESET;
            period    = PERIOD_RESET;
            for (int i = 0; i < 16; i++)
            begin
                cur_pos[i] = MID_POS;
                tgt_pos[i] = MID_POS;
            end
            elapsed       = 0;
            errors        = 0;
            commands      = 0;
            compared      = 0;
            periods_fired = 0;
            bad_chan      = 0;
        endfunction

        function void write_reg(logic [1:0] addr, logic [15:0] data);
            case (addr)
                REG_MIN_POS: lo_lim    = data[7:0];
                REG_MAX_POS: hi_lim    = data[7:0];
                REG_STEP:    step_size = data[7:0];
                REG_PERIOD:  period    = data;
                default: ;
            endcase
        endfunction

        function logic [15:0] advance_all();
            logic [15:0] mask;
            int          cur;
            int          tgt;
            int          nxt;
            mask = '0;
            for (int i = 0; i < num_chan; i++)
            begin
                cur = int'(cur_pos[i]);
                tgt = int'(tgt_pos[i]);
                nxt = cur;
                if (cur < tgt)
                begin
                    nxt = cur + int'(step_size);
                    if (nxt > tgt)
                        nxt = tgt;
                end
                else if (cur > tgt)
                begin
                    nxt = cur - int'(step_size);
                    if (nxt < tgt)
                        nxt = tgt;
                end
                if (nxt != cur)
                    mask[i] = 1'b1;
                cur_pos[i] = nxt[7:0];
            end
            return mask;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void take_command(logic [1:0] cmd, logic [3:0] ch, logic [10:0] raw);
            msl_result_t res;
            int          want;
            bit          chan_ok;
            res     = '0;
            chan_ok = int'(ch) < num_chan;
            want    = int'($signed(raw));
            commands++;
            case (cmd)
                CMD_SET:
                begin
                    if (chan_ok)
                    begin
                        // inverted limits: the lower clamp is tested first
                        if (want < int'(lo_lim))
                            want = int'(lo_lim);
                        else if (want > int'(hi_lim))
                            want = int'(hi_lim);
                        tgt_pos[ch] = want[7:0];
                    end
                    else
                    begin
                        res.status = STATUS_BAD_CHAN;
                        bad_chan++;
                    end
                end
                CMD_TICK:
                begin
                    if (elapsed < 65535)
                        elapsed++;
                    // a zero period behaves as one
                    if (elapsed >= int'(period))
                    begin
                        elapsed        = 0;
                        res.moved_mask = advance_all();
                        periods_fired++;
                    end
                end
                CMD_HALT:
                begin
                    for (int i = 0; i < num_chan; i++)
                        tgt_pos[i] = cur_pos[i];
                end
                default:
                begin
                    if (chan_ok)
                    begin
                        res.position  = cur_pos[ch];
                        res.at_target = (cur_pos[ch] == tgt_pos[ch]);
                    end
                    else
                    begin
                        res.status = STATUS_BAD_CHAN;
                        bad_chan++;
                    end
                end
            endcase
            expected_results.push_back(res);
        endfunction

        function void check_result(logic status, logic [31:0] data);
            msl_result_t exp_res;
            msl_result_t got;
            got.status     = status;
            got.position   = data[7:0];
            got.at_target  = data[8];
            got.moved_mask = data[24:9];
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: status %0b data %h",
                         $time, status, data);
                errors++;
                return;
            end
            exp_res = expected_results.pop_front();
            compared++;
            if (got.status !== exp_res.status)
            begin
                $display("%0t: status expected %0b actual %0b",
                         $time, exp_res.status, got.status);
                errors++;
            end
            if (got.position !== exp_res.position)
            begin
                $display("%0t: position expected %0d actual %0d",
                         $time, exp_res.position, got.position);
                errors++;
            end
            if (got.at_target !== exp_res.at_target)
            begin
                $display("%0t: at_target expected %0b actual %0b",
                         $time, exp_res.at_target, got.at_target);
                errors++;
            end
            if (got.moved_mask !== exp_res.moved_mask)
            begin
                $display("%0t: moved_mask expected %h actual %h",
                         $time, exp_res.moved_mask, got.moved_mask);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // channel[3:0], requested_position[14:4], zero[15]
    logic [1:0]  s_tuser;   // cmd[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // position[7:0], at_target[8], moved_mask[24:9], zero[31:25]
    logic        m_tuser;   // status[0]

    slew_tracker_t board;
    int            idle_pct;
    int            stall_pct;
    int            hold_left;
    int            cycle_count;
    int            settings_used;

    multi_channel_slew_limiter #(
        .NUM_CHANNELS (NUM_CH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("multi_channel_slew_limiter_test: done, errors");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        logic ready_next;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                ready_next = 1'b0;
            end
            else
                ready_next = ($urandom_range(99) >= stall_pct);
            m_tready <= ready_next;
        end
    end

    // outputs are stable at the falling edge, so sample there
    always @(negedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_result(m_tuser, m_tdata);
    end

    task automatic send_item(input logic [1:0] cmd, input logic [3:0] ch,
                             input logic [10:0] req);
        int   gap;
        logic ready_seen;
        gap = 0;
        while (idle_pct != 0 && gap < 40 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, req, ch};
        do
        begin
            @(negedge clk);
            ready_seen = s_tready;
            @(posedge clk);
        end
        while (!ready_seen);
        board.take_command(cmd, ch, req);
    endtask

    // wait until every result is back and the channel walk has finished
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (NUM_CH + 6) @(posedge clk);
    endtask

    task automatic put_reg(input logic [1:0] addr, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        board.write_reg(addr, data);
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [7:0] lo, input logic [7:0] hi,
                              input logic [7:0] st, input logic [15:0] per);
        drain();
        put_reg(REG_MIN_POS, {8'h00, lo});
        put_reg(REG_MAX_POS, {8'h00, hi});
        put_reg(REG_STEP, {8'h00, st});
        put_reg(REG_PERIOD, per);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic send_random();
        int          pick;
        logic [1:0]  cmd;
        logic [3:0]  ch;
        logic [10:0] req;
        pick = $urandom_range(99);
        if (pick < 30)
            cmd = CMD_SET;
        else if (pick < 68)
            cmd = CMD_TICK;
        else if (pick < 73)
            cmd = CMD_HALT;
        else
            cmd = CMD_QUERY;
        if ($urandom_range(99) < 85)
            ch = 4'($urandom_range(NUM_CH - 1, 0));
        else
            ch = 4'($urandom_range(15, 0));
        if ($urandom_range(99) < 65)
            req = 11'($urandom_range(255, 0));
        else
            req = 11'($urandom_range(2047, 0));
        send_item(cmd, ch, req);
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 63; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 63; end
            default: begin idle_pct = 20; stall_pct = 20; end
        endcase
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = CMD_SET;
        m_tready      = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        hold_left     = 0;
        cycle_count   = 0;
        settings_used = 0;
        board         = new(NUM_CH);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // positions come up at the midpoint; invalid channels
        for (int i = 0; i < NUM_CH; i++)
            send_item(CMD_QUERY, i[3:0], 11'd0);
        send_item(CMD_QUERY, 4'd5, 11'h7FF);
        send_item(CMD_QUERY, 4'd15, 11'd0);
        send_item(CMD_SET, 4'd15, 11'd100);
        // clamping at both ends of the signed range
        send_item(CMD_SET, 4'd0, 11'h400);
        send_item(CMD_SET, 4'd1, 11'h3FF);
        send_item(CMD_SET, 4'd2, 11'd181);
        send_item(CMD_SET, 4'd3, 11'h7FF);
        send_item(CMD_SET, 4'd4, 11'd95);

        set_limits(8'd0, 8'd180, 8'd2, 16'd1);
        send_item(CMD_TICK, 4'd0, 11'd0);
        send_item(CMD_QUERY, 4'd0, 11'd0);
        send_item(CMD_HALT, 4'd9, 11'h555);
        send_item(CMD_TICK, 4'd15, 11'h2AA);
        send_item(CMD_QUERY, 4'd0, 11'd0);
        send_item(CMD_SET, 4'd4, 11'd255);
        send_item(CMD_TICK, 4'd0, 11'd0);
        send_item(CMD_QUERY, 4'd4, 11'd0);

        // inverted limits
        set_limits(8'd200, 8'd50, 8'd1, 16'd1);
        send_item(CMD_SET, 4'd0, 11'd100);
        send_item(CMD_SET, 4'd1, 11'd250);
        send_item(CMD_TICK, 4'd0, 11'd0);
        send_item(CMD_QUERY, 4'd1, 11'd0);

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0: set_limits(8'd0, 8'd255, 8'd1, 16'd1);
                1: set_limits(8'd10, 8'd200, 8'd255, 16'd2);
                2: set_limits(8'd200, 8'd50, 8'd7, 16'd1);
                3: set_limits(8'd0, 8'd180, 8'd2, 16'd3);
                4: set_limits(8'd255, 8'd0, 8'd3, 16'd3);
                // zero step and zero period
                5: set_limits(8'd40, 8'd40, 8'd0, 16'd0);
                6: set_limits(8'd0, 8'd255, 8'd255, 16'd65535);
                default: set_limits(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                                    8'($urandom_range(255, 1)), 16'($urandom_range(6, 1)));
            endcase
            set_idling(phase % 4);
            // long hold-off on the result side so the input backs up
            if (phase == 3)
                hold_left = 300;
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_random();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d commands over %0d register settings, %0d on invalid channels",
                 board.commands, settings_used, board.bad_chan);
        $display("%0d update periods fired, %0d results compared",
                 board.periods_fired, board.compared);
        if (board.errors == 0 && board.pending() == 0)
            $display("multi_channel_slew_limiter_test: done, clean");
        else
            $display("multi_channel_slew_limiter_test: done, errors");
        $finish;
    end

endmodule
